// ===== rtl/core/lmpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_pkg: shared types and constants
// Widths, limits, register indexes and cell types for the landmark distance
// block.
// ----------------------------------------------------------------------------
package lmpd_pkg;

  localparam int unsigned MAX_POINTS = 65536;
  localparam int unsigned MAX_GRID   = 4096;

  // Field widths
  localparam int unsigned COORD_W   = 17;
  localparam int unsigned GRID_W    = 13;
  localparam int unsigned SIZE_M1_W = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned MEAN_W    = 22;

  // Datapath widths
  localparam int unsigned PROD_W     = COORD_W + GRID_W;   // coord * (size-1)
  localparam int unsigned NUM_W      = PROD_W + 1;         // plus size*2^15
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned PIX_W      = NUM_W - FRAC_SHIFT;
  localparam int unsigned DIFF_W     = PIX_W + 1;
  localparam int unsigned ABS_W      = 13;                 // |dx| <= 8190
  localparam int unsigned SQ_W       = 2 * ABS_W;
  localparam int unsigned D2_W       = SQ_W + 1;
  localparam int unsigned RAD_W      = 44;                 // d2 << 16, even width
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned ROOT_STEPS = ROOT_W;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned SUM_W      = 38;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned DIV_CNT_W  = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(64);

  // Token passed along the root cell chain
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } root_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Grid size as used: zero reads as one, above MAX_GRID clamps.
  function automatic logic [GRID_W-1:0] eff_size(input logic [GRID_W-1:0] s);
    logic [GRID_W-1:0] r;
    if (s == '0) begin
      r = GRID_W'(1);
    end else if (s > GRID_W'(MAX_GRID)) begin
      r = GRID_W'(MAX_GRID);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lmpd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_if: stream channels
// Landmark input channel and mean result channel, valid/ready.
// ----------------------------------------------------------------------------
interface lmpd_in_if;
  import lmpd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pred_x;
  logic signed [COORD_W-1:0] pred_y;
  logic signed [COORD_W-1:0] label_x;
  logic signed [COORD_W-1:0] label_y;
  logic                      last_point;

  modport source (output valid, pred_x, pred_y, label_x, label_y, last_point,
                  input ready);
  modport sink   (input valid, pred_x, pred_y, label_x, label_y, last_point,
                  output ready);
endinterface

interface lmpd_out_if;
  import lmpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_distance;
  logic              count_overflow;

  modport source (output valid, mean_distance, count_overflow, input ready);
  modport sink   (input valid, mean_distance, count_overflow, output ready);
endinterface

// ===== rtl/core/lmpd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_front: pixel mapping and squared distance
// Five stages: scale, round to pixel, abs difference, square, sum.
// ----------------------------------------------------------------------------
module lmpd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  input  logic                               last_i,
  input  logic signed [lmpd_pkg::COORD_W-1:0] coord_i [4],  // px, py, lx, ly
  input  logic [lmpd_pkg::GRID_W-1:0]        size_x_i,
  input  logic [lmpd_pkg::GRID_W-1:0]        size_y_i,
  output lmpd_pkg::root_t                    head_o
);
  import lmpd_pkg::*;

  logic [SIZE_M1_W-1:0] sm1 [4];
  logic [GRID_W-1:0]    sz  [4];
  logic [NUM_W-1:0]     num [4];
  logic [NUM_W-1:0]     nbias [4];

  logic [3:0] vld_q;
  logic [3:0] last_q;
  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [PIX_W-1:0]  pix_q  [4];
  logic [ABS_W-1:0]         ax_q, ay_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        adx, ady;

  assign sz[0] = size_x_i;
  assign sz[1] = size_y_i;
  assign sz[2] = size_x_i;
  assign sz[3] = size_y_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sm1[i]   = SIZE_M1_W'(sz[i] - GRID_W'(1));
      num[i]   = NUM_W'($signed(prod_q[i])) + NUM_W'({sz[i], 15'b0});
      // round toward zero: bias negative numerators before the shift
      nbias[i] = num[i] + NUM_W'({FRAC_SHIFT{num[i][NUM_W-1]}});
    end
    dx  = DIFF_W'(pix_q[0]) - DIFF_W'(pix_q[2]);
    dy  = DIFF_W'(pix_q[1]) - DIFF_W'(pix_q[3]);
    adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      last_q <= '0;
      head_o <= '0;
    end else begin
      vld_q  <= {vld_q[2:0], vld_i};
      last_q <= {last_q[2:0], last_i};
      head_o.vld  <= vld_q[3];
      head_o.last <= last_q[3];
      head_o.rad  <= RAD_W'({(D2_W'(sqx_q) + D2_W'(sqy_q)), 16'b0});
      head_o.rem  <= '0;
      head_o.root <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      prod_q[i] <= PROD_W'(coord_i[i] * $signed({1'b0, sm1[i]}));
      pix_q[i]  <= $signed(nbias[i][NUM_W-1:FRAC_SHIFT]);
    end
    ax_q  <= adx[ABS_W-1:0];
    ay_q  <= ady[ABS_W-1:0];
    sqx_q <= ax_q * ax_q;
    sqy_q <= ay_q * ay_q;
  end

endmodule

// ===== rtl/core/lmpd_root_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_root_cell: one digit of the square root
// Takes two radicand bits, settles one root bit, hands on to the next cell.
// ----------------------------------------------------------------------------
module lmpd_root_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lmpd_pkg::root_t prev_i,
  output lmpd_pkg::root_t next_o
);
  import lmpd_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             take;

  assign rem_sh = {prev_i.rem, prev_i.rad[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({prev_i.root, 2'b01});
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_o <= '0;
    end else begin
      next_o.vld  <= prev_i.vld;
      next_o.last <= prev_i.last;
      next_o.rad  <= {prev_i.rad[RAD_W-3:0], 2'b00};
      next_o.rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      next_o.root <= {prev_i.root[ROOT_W-2:0], take};
    end
  end

endmodule

// ===== rtl/core/lmpd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_div: restoring divider
// Sum over count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lmpd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lmpd_pkg::SUM_W-1:0]    dividend_i,
  input  logic [lmpd_pkg::CNT_W-1:0]    divisor_i,
  output lmpd_pkg::div_stat_t           stat_o,
  output logic [lmpd_pkg::SUM_W-1:0]    quotient_o
);
  import lmpd_pkg::*;

  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     dvs_q;
  logic [SUM_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [CNT_W:0]       rem_sh;
  logic                 take;

  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign take   = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(SUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? CNT_W'(rem_sh - {1'b0, dvs_q}) : CNT_W'(rem_sh);
      quo_q <= {quo_q[SUM_W-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== rtl/core/landmark_mean_pixel_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landmark_mean_pixel_distance: mean pixel distance of landmark pairs
// Maps predicted and labelled points to the pixel grid, takes the Euclidean
// distance through a chain of root cells and reports the batch mean.
// ----------------------------------------------------------------------------
// One landmark at a time: a transfer on in_i is taken, then the point runs
// through a five-stage front end (scale, pixel rounding, difference, square,
// sum) and a row of 22 square root cells, one result bit per cell, before it
// lands in the running sum. in_i.ready drops on the transfer and comes back
// once the point lands there. On the item with last_point set, a restoring
// divider produces sum/count one bit per cycle, so the mean appears on out_o
// once the divider is done and in_i.ready stays low until then; the result
// sits in an output register and the block takes the next landmark while it
// waits for its transfer. If an earlier mean still waits there, in_i.ready
// stays low until it has gone. The distance has 8 fraction bits; the sum
// saturates at 2^38-1, the mean at 2^22-1. More than 65536 points in a batch:
// further points are dropped and count_overflow is set. Grid sizes are to
// be written through the cfg port (index 0 width, 1 height) only while the
// block is idle; the user must keep to this, as the block does not enforce
// it. 0 acts as 1 and values above 4096 as 4096.
// ----------------------------------------------------------------------------
module landmark_mean_pixel_distance (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lmpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lmpd_pkg::GRID_W-1:0]      cfg_wdata_i,
  lmpd_in_if.sink                          in_i,
  lmpd_out_if.source                       out_o
);
  import lmpd_pkg::*;

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;  // ready for a landmark
  localparam logic [1:0] ST_RUN  = 2'd1;  // landmark in the pipe
  localparam logic [1:0] ST_DIV  = 2'd2;  // mean being divided
  localparam logic [1:0] ST_HOLD = 2'd3;  // mean waits for the output reg

  logic [1:0] state_q, state_d;

  // grid size registers
  logic [GRID_W-1:0] gw_q, gh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GRID_RESET;
      gh_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  gw_q <= cfg_wdata_i;
        CFG_GRID_HEIGHT: gh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front end
  logic                      in_xfer;
  logic signed [COORD_W-1:0] coords [4];
  root_t                     chain [ROOT_STEPS+1];
  logic [ROOT_STEPS-1:0]     chain_vld;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  assign coords[0] = in_i.pred_x;
  assign coords[1] = in_i.pred_y;
  assign coords[2] = in_i.label_x;
  assign coords[3] = in_i.label_y;

  lmpd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (in_xfer),
    .last_i   (in_i.last_point),
    .coord_i  (coords),
    .size_x_i (eff_size(gw_q)),
    .size_y_i (eff_size(gh_q)),
    .head_o   (chain[0])
  );

  // square root chain
  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    lmpd_root_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .prev_i (chain[g]),
      .next_o (chain[g+1])
    );
    assign chain_vld[g] = chain[g+1].vld;
  end

  root_t tail;
  assign tail = chain[ROOT_STEPS];

  // running sum and count
  logic [SUM_W-1:0] sum_q, sum_n;
  logic [CNT_W-1:0] cnt_q, cnt_n;
  logic             ovf_q, ovf_n;
  logic             ovf_res_q;
  logic [SUM_W:0]   sum_add;
  logic             cnt_full;
  logic             div_start;

  always_comb begin
    sum_add  = {1'b0, sum_q} + (SUM_W+1)'(tail.root);
    cnt_full = (cnt_q == CNT_W'(MAX_POINTS));
    if (cnt_full) begin
      sum_n = sum_q;
      cnt_n = cnt_q;
    end else begin
      sum_n = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      cnt_n = cnt_q + CNT_W'(1);
    end
    ovf_n = ovf_q | cnt_full;
  end

  assign div_start = tail.vld && tail.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      ovf_res_q <= 1'b0;
    end else if (tail.vld) begin
      if (tail.last) begin
        // batch closes: divider takes the totals, sums restart
        ovf_res_q <= ovf_n;
        sum_q     <= '0;
        cnt_q     <= '0;
        ovf_q     <= 1'b0;
      end else begin
        sum_q <= sum_n;
        cnt_q <= cnt_n;
        ovf_q <= ovf_n;
      end
    end
  end

  // mean
  div_stat_t        div_stat;
  logic [SUM_W-1:0] quo;

  lmpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_n),
    .divisor_i  (cnt_n),
    .stat_o     (div_stat),
    .quotient_o (quo)
  );

  // output register
  logic              out_vld_q;
  logic [MEAN_W-1:0] mean_q;
  logic              ovf_out_q;
  logic              res_rdy;
  logic              out_free;
  logic              out_load;

  assign res_rdy  = ((state_q == ST_DIV) && div_stat.done) || (state_q == ST_HOLD);
  assign out_free = !out_vld_q || out_o.ready;
  assign out_load = res_rdy && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q    <= (|quo[SUM_W-1:MEAN_W]) ? '1 : quo[MEAN_W-1:0];
      ovf_out_q <= ovf_res_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.mean_distance  = mean_q;
  assign out_o.count_overflow = ovf_out_q;

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (tail.vld) state_d = tail.last ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_stat.done) state_d = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld))
    else $error("more than one landmark in the root chain");

  a_tail_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> (state_q == ST_RUN))
    else $error("root chain result outside run state");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
    else $error("divider active outside divide state");

  a_xfer_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_RUN))
    else $error("input transfer did not start a run");

  a_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == ST_IDLE))
    else $error("result loaded without returning to idle");

endmodule

// ===== tb/tb_landmark_mean_pixel_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_landmark_mean_pixel_distance: self-checking bench for the landmark mean
// Streams landmark pairs in batches under several grid sizes and randomized
// backpressure. A scoreboard predicts each batch mean and checks every result.
// ----------------------------------------------------------------------------
module tb_landmark_mean_pixel_distance;
  import lmpd_pkg::*;

  // Predicts the batch mean from the accepted landmarks and checks results.
  class mean_dist_scoreboard;
    typedef struct {
      logic [MEAN_W-1:0] mean;
      logic              ovf;
    } batch_mean_t;

    logic [GRID_W-1:0] grid_w_reg;
    logic [GRID_W-1:0] grid_h_reg;
    longint unsigned   dist_sum;
    int unsigned       pt_count;
    bit                ovf_seen;
    batch_mean_t       mean_q[$];
    int unsigned       errors;

    function new();
      grid_w_reg = GRID_RESET;
      grid_h_reg = GRID_RESET;
      dist_sum   = 0;
      pt_count   = 0;
      ovf_seen   = 1'b0;
      errors     = 0;
    endfunction

    function void set_grid(logic [CFG_IDX_W-1:0] idx, logic [GRID_W-1:0] val);
      if (idx == CFG_GRID_WIDTH) begin
        grid_w_reg = val;
      end else if (idx == CFG_GRID_HEIGHT) begin
        grid_h_reg = val;
      end
    endfunction

    function int pending();
      return mean_q.size();
    endfunction

    // zero acts as one, oversize clamps
    function int grid_used(logic [GRID_W-1:0] r);
      if (r == '0) return 1;
      if (r > GRID_W'(MAX_GRID)) return MAX_GRID;
      return int'(r);
    endfunction

    // (coord*(size-1) + size*2^15) / 2^16, truncated toward zero
    function longint to_pixel(int coord, int size);
      return (longint'(coord) * (size - 1) + longint'(size) * 32768) / 65536;
    endfunction

    // floor(sqrt(d2 * 2^16)): distance with 8 fraction bits
    function longint unsigned dist_q8(longint unsigned d2);
      longint unsigned rad;
      longint unsigned root;
      longint unsigned trial;
      rad  = d2 << 16;
      root = 0;
      for (int b = ROOT_W; b >= 0; b--) begin
        trial = root | (longint'(1) << b);
        if (trial * trial <= rad) root = trial;
      end
      return root;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void note_point(int px, int py, int lx, int ly, bit last);
      int              sw;
      int              sh;
      longint          dx;
      longint          dy;
      longint unsigned pt_dist;
      longint unsigned mean;
      longint unsigned sum_sat;
      batch_mean_t     rec;
      sum_sat = (longint'(1) << SUM_W) - 1;
      sw      = grid_used(grid_w_reg);
      sh      = grid_used(grid_h_reg);
      dx      = to_pixel(px, sw) - to_pixel(lx, sw);
      dy      = to_pixel(py, sh) - to_pixel(ly, sh);
      pt_dist = dist_q8(longint'(dx * dx + dy * dy));
      if (pt_count >= MAX_POINTS) begin
        ovf_seen = 1'b1;
      end else begin
        pt_count++;
        dist_sum += pt_dist;
        if (dist_sum > sum_sat) dist_sum = sum_sat;
      end
      if (!last) return;
      mean = dist_sum / pt_count;
      if (mean > (longint'(1) << MEAN_W) - 1) mean = (longint'(1) << MEAN_W) - 1;
      rec.mean = mean[MEAN_W-1:0];
      rec.ovf  = ovf_seen;
      mean_q.push_back(rec);
      dist_sum = 0;
      pt_count = 0;
      ovf_seen = 1'b0;
    endfunction

    function void check_mean(logic [MEAN_W-1:0] mean, logic ovf);
      batch_mean_t exp_rec;
      if (mean_q.size() == 0) begin
        flag($sformatf("result with no batch pending: mean=%0d ovf=%0b", mean, ovf));
        return;
      end
      exp_rec = mean_q.pop_front();
      if (mean !== exp_rec.mean)
        flag($sformatf("mean_distance exp=%0d act=%0d", exp_rec.mean, mean));
      if (ovf !== exp_rec.ovf)
        flag($sformatf("count_overflow exp=%0b act=%0b", exp_rec.ovf, ovf));
    endfunction
  endclass

  // The drain waits long enough for ready to come back after a transfer and
  // for the mean to show up after the last point, with margin.
  localparam int unsigned DRAIN_CYCLES    = 100;
  // Longest legal quiet stretch is a drain plus a sender gap plus a stall;
  // the watchdog allows many times that.
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned RANDOM_SEGMENTS = 8;
  localparam int unsigned SEGMENT_POINTS  = 128;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [GRID_W-1:0]    cfg_wdata_i;

  lmpd_in_if  in_ch ();
  lmpd_out_if out_ch ();

  landmark_mean_pixel_distance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  mean_dist_scoreboard sb = new();

  int in_idle_pct  = 0;   // chance per cycle of a sender gap
  int out_idle_pct = 0;   // chance per cycle of a result stall
  int quiet_cycles = 0;
  int seg_points   = 0;

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Result side backpressure, drawn fresh every cycle
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= out_idle_pct);
  end

  // Monitors and watchdog, all sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      sb.note_point(in_ch.pred_x, in_ch.pred_y, in_ch.label_x, in_ch.label_y,
                    in_ch.last_point);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_mean(out_ch.mean_distance, out_ch.count_overflow);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_landmark(input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py,
                               input logic signed [COORD_W-1:0] lx,
                               input logic signed [COORD_W-1:0] ly,
                               input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.pred_x     = px;
    in_ch.pred_y     = py;
    in_ch.label_x    = lx;
    in_ch.label_y    = ly;
    in_ch.last_point = last;
    in_ch.valid      = 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    @(negedge clk_i);
    seg_points++;
  endtask

  // Mostly full-range values, some corners, some small magnitudes
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int corners[7] = '{-65536, -32768, -1, 0, 1, 32767, 65535};
    case ($urandom_range(9))
      0, 1:    return COORD_W'(corners[$urandom_range(0, 6)]);
      2:       return COORD_W'(int'($urandom_range(0, 2047)) - 1024);
      default: return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    endcase
  endfunction

  // Half the time the prediction lands near the label, as a trained net would
  task automatic send_random_landmark(input logic last);
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    lx = rand_coord();
    ly = rand_coord();
    if ($urandom_range(1)) begin
      px = COORD_W'(int'(lx) + int'($urandom_range(0, 2047)) - 1024);
      py = COORD_W'(int'(ly) + int'($urandom_range(0, 2047)) - 1024);
    end else begin
      px = rand_coord();
      py = rand_coord();
    end
    send_landmark(px, py, lx, ly, last);
  endtask

  // Single points, short and long batches
  function automatic int batch_len();
    case ($urandom_range(9))
      0, 1:    return 1;
      8, 9:    return $urandom_range(17, 60);
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  // Sender holds off until every pending mean has arrived and the pipe is empty
  task automatic wait_batches_done();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One write, only while the block is idle
  task automatic write_grid(input logic [CFG_IDX_W-1:0] idx,
                            input logic [GRID_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.set_grid(idx, val);
  endtask

  initial begin
    int               n;
    logic [GRID_W-1:0] gw;
    logic [GRID_W-1:0] gh;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_GRID_WIDTH;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.pred_x     = '0;
    in_ch.pred_y     = '0;
    in_ch.label_x    = '0;
    in_ch.label_y    = '0;
    in_ch.last_point = 1'b0;
    in_idle_pct      = 32;
    out_idle_pct     = 54;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed: reset grid 64x64 ---
    send_landmark(0, 0, 0, 0, 1'b1);                        // zero distance, one point
    send_landmark(65535, 65535, -65536, -65536, 1'b1);      // opposite corners
    send_landmark(-65536, 65535, 65535, -65536, 1'b0);
    send_landmark(32768, -32768, -32768, 32768, 1'b0);
    send_landmark(1, -1, -1, 1, 1'b1);                      // rounding near center
    send_landmark(-1, -1, 0, 0, 1'b0);
    send_landmark(32767, 0, -32768, 0, 1'b1);

    // width zero reads as one, height all ones clamps
    wait_batches_done();
    write_grid(CFG_GRID_WIDTH, GRID_W'(0));
    write_grid(CFG_GRID_HEIGHT, GRID_W'(8191));
    send_landmark(65535, 65535, -65536, -65536, 1'b0);
    send_landmark(-65536, -65536, 65535, 65535, 1'b0);
    send_landmark(0, 1, 0, -1, 1'b1);

    // just past the grid limit, and the smallest real size
    wait_batches_done();
    write_grid(CFG_GRID_WIDTH, GRID_W'(MAX_GRID + 1));
    write_grid(CFG_GRID_HEIGHT, GRID_W'(1));
    send_landmark(65535, 0, -65536, 0, 1'b1);
    send_landmark(-65536, 65535, 65535, -65536, 1'b1);

    // largest grid: biggest distance the datapath sees
    wait_batches_done();
    write_grid(CFG_GRID_WIDTH, GRID_W'(MAX_GRID));
    write_grid(CFG_GRID_HEIGHT, GRID_W'(MAX_GRID));
    send_landmark(65535, 65535, -65536, -65536, 1'b0);
    send_landmark(-65536, 65535, 65535, -65536, 1'b1);
    send_landmark(12345, -12345, 12345, -12345, 1'b1);

    // --- random batches, one grid setting per segment ---
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      if (seg < 3) begin
        in_idle_pct  = 32;
        out_idle_pct = 54;
      end else if (seg < 6) begin
        in_idle_pct  = 54;
        out_idle_pct = 32;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (seg)
        0: begin gw = GRID_W'(0);        gh = GRID_W'(8191); end
        1: begin gw = GRID_W'(MAX_GRID); gh = GRID_W'(1);    end
        2: begin gw = GRID_W'(1);        gh = GRID_W'(MAX_GRID + 1); end
        3: begin gw = GRID_W'(2);        gh = GRID_W'(MAX_GRID - 1); end
        5: begin
          gw = GRID_W'($urandom_range(0, (1 << GRID_W) - 1));
          gh = GRID_W'($urandom_range(0, (1 << GRID_W) - 1));
        end
        7: begin gw = GRID_W'(MAX_GRID); gh = GRID_W'(MAX_GRID); end
        default: begin
          gw = GRID_W'($urandom_range(1, MAX_GRID));
          gh = GRID_W'($urandom_range(1, MAX_GRID));
        end
      endcase
      wait_batches_done();
      write_grid(CFG_GRID_WIDTH, gw);
      write_grid(CFG_GRID_HEIGHT, gh);
      seg_points = 0;
      // every segment closes on a last point so the sums start clean
      while (seg_points < SEGMENT_POINTS) begin
        n = batch_len();
        for (int i = 0; i < n; i++) send_random_landmark(i == n - 1);
      end
    end

    wait_batches_done();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Errors: %0d, batches still pending: %0d", sb.errors, sb.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
